// ===== rtl/core/eoq_pkg.sv =====
// Shared constants, types and tables for the Euler offset to quaternion core.
package eoq_pkg;

   localparam int ANGLE_FRAC_BITS = 6;
   localparam int TRIG_ITERATIONS = 16;
   localparam int ATAN_TABLE_LEN  = 24;
   localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_TABLE_LEN) ?
                                    TRIG_ITERATIONS : ATAN_TABLE_LEN;

   localparam int FIELD_W = 16;
   localparam int DIFF_W  = FIELD_W + 1;   // wrapped angle minus offset
   localparam int PROD_W  = 2 * DIFF_W;    // difference times gain
   localparam int HANG_W  = DIFF_W + 2;    // half angle before and after folding
   localparam int VEC_W   = 36;            // Q2.30 vector and 2^-24 degree angle
   localparam int TRIG_W  = 17;            // Q1.15 cos or sin, +-1.0 inclusive
   localparam int PAIR_W  = 2 * TRIG_W;
   localparam int TRIP_W  = PAIR_W + TRIG_W;

   // angle limits in input units
   localparam logic signed [HANG_W-1:0] ANG_HALF = HANG_W'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [HANG_W-1:0] ANG_FULL = HANG_W'(360 << ANGLE_FRAC_BITS);
   // same limits in half-angle units
   localparam logic signed [HANG_W-1:0] HA_QUARTER = HANG_W'(90 << (ANGLE_FRAC_BITS + 1));
   localparam logic signed [HANG_W-1:0] HA_HALF    = HANG_W'(180 << (ANGLE_FRAC_BITS + 1));
   localparam logic signed [HANG_W-1:0] HA_FULL    = HANG_W'(360 << (ANGLE_FRAC_BITS + 1));
   localparam int Z_SHIFT = 23 - ANGLE_FRAC_BITS;

   localparam logic signed [VEC_W-1:0] CORDIC_START = VEC_W'(652032875);
   localparam logic [15:0] GAIN_RESET = 16'd32768;

   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [HANG_W-1:0] hang_type;

   function automatic vec_type atan_deg24(input int idx);
      vec_type v;
      case (idx)
         0:  v = VEC_W'(754974720);
         1:  v = VEC_W'(445687602);
         2:  v = VEC_W'(235489089);
         3:  v = VEC_W'(119537938);
         4:  v = VEC_W'(60000935);
         5:  v = VEC_W'(30029717);
         6:  v = VEC_W'(15018523);
         7:  v = VEC_W'(7509719);
         8:  v = VEC_W'(3754917);
         9:  v = VEC_W'(1877465);
         10: v = VEC_W'(938734);
         11: v = VEC_W'(469367);
         12: v = VEC_W'(234684);
         13: v = VEC_W'(117342);
         14: v = VEC_W'(58671);
         15: v = VEC_W'(29335);
         16: v = VEC_W'(14668);
         17: v = VEC_W'(7334);
         18: v = VEC_W'(3667);
         19: v = VEC_W'(1833);
         20: v = VEC_W'(917);
         21: v = VEC_W'(458);
         22: v = VEC_W'(229);
         23: v = VEC_W'(115);
         default: v = '0;
      endcase
      return v;
   endfunction

   // single wrap toward +-180 degrees
   function automatic hang_type wrap_once(input hang_type a);
      hang_type r;
      if (a < -ANG_HALF) begin
         r = a + ANG_FULL;
      end else if (a > ANG_HALF) begin
         r = a - ANG_FULL;
      end else begin
         r = a;
      end
      return r;
   endfunction

   // Q2.30 to Q1.15, round half up, clamp to +-1.0
   function automatic trig_type q30_to_q15(input vec_type v);
      logic signed [VEC_W-16:0] r;
      trig_type o;
      r = (VEC_W-15)'((v + VEC_W'(16384)) >>> 15);
      if (r > (VEC_W-15)'(32768)) begin
         o = TRIG_W'(32768);
      end else if (r < -(VEC_W-15)'(32768)) begin
         o = -TRIG_W'(32768);
      end else begin
         o = TRIG_W'(r);
      end
      return o;
   endfunction

   // Q1.45 sum to Q1.15, round half up, saturate
   function automatic logic signed [FIELD_W-1:0] out_q15(input logic signed [TRIP_W-1:0] v);
      logic signed [TRIP_W-30:0] r;
      logic signed [FIELD_W-1:0] o;
      r = (TRIP_W-29)'((v + TRIP_W'(1 << 29)) >>> 30);
      if (r > (TRIP_W-29)'(32767)) begin
         o = 16'sh7FFF;
      end else if (r < -(TRIP_W-29)'(32768)) begin
         o = 16'sh8000;
      end else begin
         o = FIELD_W'(r);
      end
      return o;
   endfunction

endpackage

// ===== rtl/core/euler_offset_to_quaternion_core.sv =====
// Top level: offset-corrected Euler angles to Q1.15 quaternion, pipelined CORDIC.
//
//  channel  ports                          direction  handshake
//  req      req_pitch/roll/yaw_in          in         req_valid / req_ready
//  rsp      rsp_quat_w/x/y/z               out        rsp_valid / rsp_ready
//  csr      csr_sensitivity_gain           in         csr_valid / csr_ready
//
// One transaction enters per cycle while rsp_ready does not stall the pipeline, which has
// one register stage per CORDIC step plus the scale, fold and product stages.
// The first transaction after reset only loads the zero offset and gives no result.
// Synchronous reset clears the valid bits and the offset flag and loads the default gain.
// A stalled stage holds while upstream stages fill any empty slot behind it.
module euler_offset_to_quaternion_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [eoq_pkg::FIELD_W-1:0] req_pitch_in,
   input  logic signed [eoq_pkg::FIELD_W-1:0] req_roll_in,
   input  logic signed [eoq_pkg::FIELD_W-1:0] req_yaw_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [eoq_pkg::FIELD_W-1:0] rsp_quat_w,
   output logic signed [eoq_pkg::FIELD_W-1:0] rsp_quat_x,
   output logic signed [eoq_pkg::FIELD_W-1:0] rsp_quat_y,
   output logic signed [eoq_pkg::FIELD_W-1:0] rsp_quat_z,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [15:0]                    csr_sensitivity_gain
);
   import eoq_pkg::*;

   // stage map
   localparam int ST_DIFF = 0;
   localparam int ST_PROD = 1;
   localparam int ST_HANG = 2;
   localparam int ST_COR0 = 3;                     // CORDIC start, then one per step
   localparam int ST_CS   = ST_COR0 + CORDIC_STEPS + 1;
   localparam int ST_PAIR = ST_CS + 1;
   localparam int ST_TRIP = ST_PAIR + 1;
   localparam int ST_OUT  = ST_TRIP + 1;
   localparam int NSTG    = ST_OUT + 1;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG:0]   rdy;
   logic            req_fire;

   logic [15:0] gain_ff;
   logic        zero_captured_ff;
   hang_type    zero_ff   [3];
   hang_type    wrap_in   [3];

   logic signed [DIFF_W-1:0] diff_ff [3];
   logic signed [PROD_W-1:0] prod_ff [3];
   hang_type                 hang_ff [3];
   vec_type  cx_ff [CORDIC_STEPS+1][3];
   vec_type  cy_ff [CORDIC_STEPS+1][3];
   vec_type  cz_ff [CORDIC_STEPS+1][3];
   logic     neg_ff [CORDIC_STEPS+1][3];
   trig_type cos_ff [3];
   trig_type sin_ff [3];
   // lane 0 yaw, 1 roll, 2 pitch
   logic signed [PAIR_W-1:0] pair_ff [4];   // cy*cr, sy*sr, cy*sr, sy*cr
   // pitch cos and sin ride one stage with the pair products
   trig_type pcos_ff, psin_ff;
   logic signed [TRIP_W-1:0] trip_ff [8];
   logic signed [FIELD_W-1:0] qw_ff, qx_ff, qy_ff, qz_ff;

   always_comb begin
      rdy[NSTG] = rsp_ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_ready = rdy[0];
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      wrap_in[0] = wrap_once(HANG_W'(req_yaw_in));
      wrap_in[1] = wrap_once(HANG_W'(req_roll_in));
      wrap_in[2] = wrap_once(HANG_W'(req_pitch_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff          <= GAIN_RESET;
         zero_captured_ff <= 1'b0;
         for (int l = 0; l < 3; l++) begin
            zero_ff[l] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            gain_ff <= csr_sensitivity_gain;
         end
         // first transaction loads the offset
         if (req_fire && !zero_captured_ff) begin
            zero_captured_ff <= 1'b1;
            for (int l = 0; l < 3; l++) begin
               zero_ff[l] <= wrap_in[l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[ST_DIFF]) begin
            vld_ff[ST_DIFF] <= req_fire && zero_captured_ff;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // offset, gain, wrap and fold
   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         hang_type a;
         hang_type r;
         logic     n;
         if (rdy[ST_DIFF]) begin
            diff_ff[l] <= DIFF_W'(wrap_in[l] - zero_ff[l]);
         end
         if (rdy[ST_PROD]) begin
            prod_ff[l] <= diff_ff[l] * $signed({1'b0, gain_ff});
         end
         if (rdy[ST_HANG]) begin
            a = HANG_W'((prod_ff[l] + PROD_W'(16384)) >>> 15);
            hang_ff[l] <= wrap_once(a);
         end
         if (rdy[ST_COR0]) begin
            r = hang_ff[l];
            n = 1'b0;
            if (r > HA_HALF) begin
               r = r - HA_FULL;
            end else if (r <= -HA_HALF) begin
               r = r + HA_FULL;
            end
            if (r > HA_QUARTER) begin
               r = r - HA_HALF;
               n = 1'b1;
            end else if (r < -HA_QUARTER) begin
               r = r + HA_HALF;
               n = 1'b1;
            end
            cx_ff[0][l]  <= CORDIC_START;
            cy_ff[0][l]  <= '0;
            cz_ff[0][l]  <= VEC_W'(r) <<< Z_SHIFT;
            neg_ff[0][l] <= n;
         end
      end
   end

   // rotation CORDIC, one step per stage
   always_ff @(posedge clock) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (rdy[ST_COR0 + 1 + i]) begin
            for (int l = 0; l < 3; l++) begin
               if (cz_ff[i][l] >= 0) begin
                  cx_ff[i+1][l] <= cx_ff[i][l] - (cy_ff[i][l] >>> i);
                  cy_ff[i+1][l] <= cy_ff[i][l] + (cx_ff[i][l] >>> i);
                  cz_ff[i+1][l] <= cz_ff[i][l] - atan_deg24(i);
               end else begin
                  cx_ff[i+1][l] <= cx_ff[i][l] + (cy_ff[i][l] >>> i);
                  cy_ff[i+1][l] <= cy_ff[i][l] - (cx_ff[i][l] >>> i);
                  cz_ff[i+1][l] <= cz_ff[i][l] + atan_deg24(i);
               end
               neg_ff[i+1][l] <= neg_ff[i][l];
            end
         end
      end
   end

   // round, clamp, products and sums
   always_ff @(posedge clock) begin
      if (rdy[ST_CS]) begin
         for (int l = 0; l < 3; l++) begin
            if (neg_ff[CORDIC_STEPS][l]) begin
               cos_ff[l] <= -q30_to_q15(cx_ff[CORDIC_STEPS][l]);
               sin_ff[l] <= -q30_to_q15(cy_ff[CORDIC_STEPS][l]);
            end else begin
               cos_ff[l] <= q30_to_q15(cx_ff[CORDIC_STEPS][l]);
               sin_ff[l] <= q30_to_q15(cy_ff[CORDIC_STEPS][l]);
            end
         end
      end
      if (rdy[ST_PAIR]) begin
         pair_ff[0] <= cos_ff[0] * cos_ff[1];
         pair_ff[1] <= sin_ff[0] * sin_ff[1];
         pair_ff[2] <= cos_ff[0] * sin_ff[1];
         pair_ff[3] <= sin_ff[0] * cos_ff[1];
      end
      if (rdy[ST_TRIP]) begin
         trip_ff[0] <= pair_ff[0] * pcos_ff;
         trip_ff[1] <= pair_ff[1] * psin_ff;
         trip_ff[2] <= pair_ff[2] * pcos_ff;
         trip_ff[3] <= pair_ff[3] * psin_ff;
         trip_ff[4] <= pair_ff[3] * pcos_ff;
         trip_ff[5] <= pair_ff[2] * psin_ff;
         trip_ff[6] <= pair_ff[0] * psin_ff;
         trip_ff[7] <= pair_ff[1] * pcos_ff;
      end
      if (rdy[ST_OUT]) begin
         qw_ff <= out_q15(trip_ff[0] + trip_ff[1]);
         qx_ff <= out_q15(-(trip_ff[2] - trip_ff[3]));
         qy_ff <= out_q15(trip_ff[4] - trip_ff[5]);
         qz_ff <= out_q15(-(trip_ff[6] + trip_ff[7]));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_PAIR]) begin
         pcos_ff <= cos_ff[2];
         psin_ff <= sin_ff[2];
      end
   end

   assign rsp_valid  = vld_ff[ST_OUT];
   assign rsp_quat_w = qw_ff;
   assign rsp_quat_x = qx_ff;
   assign rsp_quat_y = qy_ff;
   assign rsp_quat_z = qz_ff;

   a_no_result_before_offset: assert property (@(posedge clock) disable iff (reset)
      !zero_captured_ff |-> vld_ff == '0)
      else $error("pipeline holds a transaction before the offset is loaded");

   a_offset_load_gives_no_item: assert property (@(posedge clock) disable iff (reset)
      req_fire && !zero_captured_ff |=> zero_captured_ff && !vld_ff[ST_DIFF])
      else $error("offset transaction entered the pipeline");

   a_stall_holds_output: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT] && !rsp_ready |=>
         vld_ff[ST_OUT] && $stable({qw_ff, qx_ff, qy_ff, qz_ff}))
      else $error("stalled result dropped");

endmodule

// ===== verif/euler_offset_to_quaternion_core_tb.sv =====
// Testbench for the Euler offset to quaternion core: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module euler_offset_to_quaternion_core_tb;
   import eoq_pkg::*;

   typedef struct {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   // ---------------- predictor ----------------
   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-(v + 1)) >>> s) + 1);
   endfunction

   function automatic longint wrap_angle(longint a);
      longint h, f;
      h = 180 << ANGLE_FRAC_BITS;
      f = 360 << ANGLE_FRAC_BITS;
      if (a < -h) return a + f;
      if (a > h) return a - f;
      return a;
   endfunction

   function automatic longint trig_round(longint v);
      longint r;
      r = floor_shift(v + (64'sd1 <<< 14), 15);
      if (r > 32768) r = 32768;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic longint atan_step(int i);
      longint t [24];
      t = '{754974720, 445687602, 235489089, 119537938, 60000935, 30029717,
            15018523, 7509719, 3754917, 1877465, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334,
            3667, 1833, 917, 458, 229, 115};
      return t[i];
   endfunction

   task automatic half_trig(input longint h, output longint c, output longint s);
      longint full, half, quarter, r, vx, vy, vz, dx, dy;
      bit flip;
      full = 360 << (ANGLE_FRAC_BITS + 1);
      half = 180 << (ANGLE_FRAC_BITS + 1);
      quarter = 90 << (ANGLE_FRAC_BITS + 1);
      r = h % full;
      flip = 0;
      if (r > half) r -= full;
      else if (r <= -half) r += full;
      if (r > quarter) begin
         r -= half; flip = 1;
      end else if (r < -quarter) begin
         r += half; flip = 1;
      end
      vz = r * (64'sd1 <<< (23 - ANGLE_FRAC_BITS));
      vx = 652032875;
      vy = 0;
      for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
         dx = floor_shift(vy, i);
         dy = floor_shift(vx, i);
         if (vz >= 0) begin
            vx -= dx; vy += dy; vz -= atan_step(i);
         end else begin
            vx += dx; vy -= dy; vz += atan_step(i);
         end
      end
      c = trig_round(vx);
      s = trig_round(vy);
      if (flip) begin
         c = -c; s = -s;
      end
   endtask

   function automatic logic signed [15:0] sum_round(longint v);
      longint r;
      r = floor_shift(v + (64'sd1 <<< 29), 30);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // ---------------- scoreboard ----------------
   class quat_scoreboard;
      bit offset_held;
      longint off_p, off_r, off_y;
      longint gain;
      quat_type pending[$];
      int mismatches;
      int checked;
      int first_seen;

      function new();
         gain = 32768;
      endfunction

      function longint scale_angle(longint a, longint off);
         return wrap_angle(floor_shift((a - off) * gain + (64'sd1 <<< 14), 15));
      endfunction

      task note_reading(logic signed [15:0] p_in, logic signed [15:0] r_in,
                        logic signed [15:0] y_in);
         longint p, r, y, cy, sy, cr, sr, cp, sp;
         quat_type q;
         p = wrap_angle(longint'(p_in));
         r = wrap_angle(longint'(r_in));
         y = wrap_angle(longint'(y_in));
         if (!offset_held) begin
            off_p = p; off_r = r; off_y = y;
            offset_held = 1;
            first_seen++;
            return;
         end
         p = scale_angle(p, off_p);
         r = scale_angle(r, off_r);
         y = scale_angle(y, off_y);
         half_trig(y, cy, sy);
         half_trig(r, cr, sr);
         half_trig(p, cp, sp);
         q.w = sum_round(cy * cr * cp + sy * sr * sp);
         q.x = sum_round(-(cy * sr * cp - sy * cr * sp));
         q.y = sum_round(sy * cr * cp - cy * sr * sp);
         q.z = sum_round(-(cy * cr * sp + sy * sr * cp));
         pending.push_back(q);
      endtask

      function void check_quat(quat_type got);
         quat_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected quaternion w=%0d x=%0d y=%0d z=%0d",
                     $time, got.w, got.x, got.y, got.z);
            mismatches++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e.w !== got.w) begin
            $display("%0t: w expected %0d actual %0d", $time, e.w, got.w); mismatches++;
         end
         if (e.x !== got.x) begin
            $display("%0t: x expected %0d actual %0d", $time, e.x, got.x); mismatches++;
         end
         if (e.y !== got.y) begin
            $display("%0t: y expected %0d actual %0d", $time, e.y, got.y); mismatches++;
         end
         if (e.z !== got.z) begin
            $display("%0t: z expected %0d actual %0d", $time, e.z, got.z); mismatches++;
         end
      endfunction
   endclass

   // ---------------- block ----------------
   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic signed [15:0] req_pitch_in = 0, req_roll_in = 0, req_yaw_in = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic csr_valid = 0, csr_ready;
   logic [15:0] csr_sensitivity_gain = 0;

   euler_offset_to_quaternion_core i_dut (.*);

   always #5 clock = ~clock;

   quat_scoreboard quat_sb = new();
   bit rsp_idle_on = 1;
   bit send_idle_on = 1;
   int idle_cycles;
   int gains_written;

   // sample on the rising edge
   always @(posedge clock) begin
      quat_type got;
      if (!reset) begin
         if (req_valid && req_ready) quat_sb.note_reading(req_pitch_in, req_roll_in, req_yaw_in);
         if (rsp_valid && rsp_ready) begin
            got.w = rsp_quat_w; got.x = rsp_quat_x; got.y = rsp_quat_y; got.z = rsp_quat_z;
            quat_sb.check_quat(got);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("euler_offset_to_quaternion_core_tb: FAIL");
            $finish;
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_ready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1;
      end
   end

   // valid stays high between back-to-back transactions; drop it only for idling and in drain
   task automatic send_reading(input logic signed [15:0] p, input logic signed [15:0] r,
                               input logic signed [15:0] y);
      int n;
      if (send_idle_on && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 4);
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_pitch_in <= p; req_roll_in <= r; req_yaw_in <= y;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (quat_sb.pending.size() != 0) @(negedge clock);
      repeat (TRIG_ITERATIONS + 12) @(negedge clock);
   endtask

   task automatic write_gain(input logic [15:0] g);
      csr_sensitivity_gain <= g;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      quat_sb.gain = g;
      gains_written++;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'sd23040;
         2: return -16'sd23040;
         default: return 16'($signed($urandom_range(0, 46080)) - 23040);
      endcase
   endfunction

   initial begin
      logic signed [15:0] edges [8];
      logic [15:0] gain_set [6];
      edges = '{0, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11521, 16'sd11521,
                16'sh7FFF, 16'sh8000};
      gain_set = '{16'd0, 16'd32768, 16'd16384, 16'd65535, 16'd1, 16'd40000};
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // first reading sets the offset, then the extremes
      send_reading(16'sd100, -16'sd200, 16'sd300);
      send_reading(16'sd100, -16'sd200, 16'sd300);
      for (int i = 0; i < 8; i++)
         send_reading(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
      send_reading(16'sh5555, 16'shAAAA, 16'sh0F0F);
      send_reading(16'shAAAA, 16'sh5555, 16'shF0F0);
      // hold until the pipeline is empty
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_gain(gain_set[ph]);
         for (int i = 0; i < 200; i++)
            send_reading(rand_angle(), rand_angle(), rand_angle());
         drain();
      end
      write_gain(16'($urandom));
      // no idling in the last part
      send_idle_on = 0;
      rsp_idle_on = 0;
      for (int i = 0; i < 230; i++)
         send_reading(rand_angle(), rand_angle(), rand_angle());
      drain();

      $display("Covered %0d quaternions over %0d gain settings; offset readings: %0d.",
               quat_sb.checked, gains_written, quat_sb.first_seen);
      if (quat_sb.mismatches == 0 && quat_sb.pending.size() == 0)
         $display("euler_offset_to_quaternion_core_tb: PASS");
      else
         $display("euler_offset_to_quaternion_core_tb: FAIL");
      $finish;
   end
endmodule
